// ----- hdl/rcst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rcst_pkg;

   // Payload field widths
   localparam int OP_W     = 2;
   localparam int POS_W    = 10;
   localparam int VALUE_W  = 16;
   localparam int LEN_W    = 11;
   localparam int TDATA_W  = 40;

   // Defaults for the top level parameters
   localparam int DEF_POSITIONS   = 1024;
   localparam int DEF_HEIGHT_BITS = 16;
   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

   // Operation codes carried in tuser
   localparam logic [OP_W-1:0] OP_RAISE = 2'd0;
   localparam logic [OP_W-1:0] OP_LOWER = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Width used for range and length compares
   localparam int CMP_W = 18;

endpackage

`default_nettype wire

// ----- hdl/range_clamp_segment_tree_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake             | Content
// req     | in        | req_tvalid/req_tready | tuser: operation; tdata: start, end, value
// rsp     | out       | rsp_tvalid/rsp_tready | tdata: height (reads only)
// csr     | in        | csr_valid/csr_ready   | csr_data: wall_length
//
// One item at a time. A node outside the range is visited and then returned
// from; a node fully inside is visited, has its tag read and is returned
// from; a node that is split goes through visit, read left, write left and
// read right, then write right. All tag traffic goes through the one write
// port and the one registered read port of the tag memory. After reset the
// 4*POSITIONS slots of the tag memory are cleared with req_tready low.
// A waiting result stalls only the end of the next read.

module range_clamp_segment_tree_core #(
   parameter int POSITIONS   = rcst_pkg::DEF_POSITIONS,
   parameter int HEIGHT_BITS = rcst_pkg::DEF_HEIGHT_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // [1:0] operation
   input  wire logic [rcst_pkg::OP_W-1:0]    req_tuser,
   // [9:0] range_start, [19:10] range_end, [35:20] height_value, [39:36] zero
   input  wire logic [rcst_pkg::TDATA_W-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // [15:0] height
   output logic [rcst_pkg::VALUE_W-1:0]      rsp_tdata,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [rcst_pkg::LEN_W-1:0]   csr_data
);
   import rcst_pkg::*;

   localparam int IDX_W    = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
   localparam int NODE_W   = IDX_W + 2;
   localparam int SLOTS    = 4 * POSITIONS;
   localparam int TAG_W    = 2 * HEIGHT_BITS;
   localparam int STK_D    = IDX_W + 1;
   localparam int SP_W     = $clog2(STK_D + 1);
   localparam int SI_W     = (STK_D > 1) ? $clog2(STK_D) : 1;
   localparam logic [HEIGHT_BITS-1:0] H_ONES = {HEIGHT_BITS{1'b1}};

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_VISIT = 3'd2;
   localparam logic [2:0] S_LEAF  = 3'd3;
   localparam logic [2:0] S_PD1   = 3'd4;
   localparam logic [2:0] S_PD2   = 3'd5;
   localparam logic [2:0] S_PD3   = 3'd6;
   localparam logic [2:0] S_POP   = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [NODE_W-1:0]      clr_ff, clr_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [IDX_W-1:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [NODE_W-1:0]      node_ff, node_in;
   logic [IDX_W-1:0]       qs_ff, qs_in, qe_ff, qe_in;
   logic [HEIGHT_BITS-1:0] fl_ff, fl_in, ce_ff, ce_in;
   logic                   rd_op_ff, rd_op_in;
   logic [TAG_W-1:0]       par_ff, par_in;
   logic [VALUE_W-1:0]     hgt_ff, hgt_in;
   logic [VALUE_W-1:0]     res_ff, res_in;
   logic                   rvld_ff, rvld_in;
   logic [SP_W-1:0]        sp_ff, sp_in;

   logic [IDX_W-1:0]       stk_lo_ff [STK_D];
   logic [IDX_W-1:0]       stk_hi_ff [STK_D];
   logic [NODE_W-1:0]      stk_node_ff [STK_D];
   logic                   push;

   logic [TAG_W-1:0]       mem [SLOTS];
   logic [TAG_W-1:0]       rd_ff;
   logic                   we;
   logic [NODE_W-1:0]      wa, ra;
   logic [TAG_W-1:0]       wd;

   logic [CMP_W-1:0]       len_w, last_w, qs_w, qe_w, v_w;
   logic [HEIGHT_BITS-1:0] v_sat;
   logic [IDX_W:0]         mid_sum;
   logic [IDX_W-1:0]       mid;
   logic [NODE_W-1:0]      left, right;
   logic                   outside, covered;
   logic [SI_W-1:0]        top_idx;
   logic [31:0]            floor_ext;
   logic [HEIGHT_BITS-1:0] rd_fl, rd_ce, par_fl, par_ce;

   // Compose a newer clamp (f, c) onto an older tag
   function automatic logic [TAG_W-1:0] compose(
      input logic [TAG_W-1:0] old_tag,
      input logic [HEIGHT_BITS-1:0] f,
      input logic [HEIGHT_BITS-1:0] c
   );
      logic [HEIGHT_BITS-1:0] fo, co, lim, nf, nc;
      fo = old_tag[HEIGHT_BITS-1:0];
      co = old_tag[TAG_W-1:HEIGHT_BITS];
      lim = (c < fo) ? c : fo;
      nf = (f > lim) ? f : lim;
      nc = (co < c) ? co : c;
      return {nc, nf};
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvld_ff;
   assign rsp_tdata  = res_ff;

   // Saturate length, clip range, saturate value
   always_comb begin
      len_w = CMP_W'(len_ff);
      if (len_w == '0) len_w = CMP_W'(1);
      if (len_w > CMP_W'(POSITIONS)) len_w = CMP_W'(POSITIONS);
      last_w = len_w - CMP_W'(1);
      qs_w = CMP_W'(req_tdata[POS_W-1:0]);
      qe_w = CMP_W'(req_tdata[2*POS_W-1:POS_W]);
      if (qe_w > last_w) qe_w = last_w;
      v_w = CMP_W'(req_tdata[2*POS_W+VALUE_W-1:2*POS_W]);
      v_sat = (v_w > CMP_W'(H_ONES)) ? H_ONES : HEIGHT_BITS'(v_w);
   end

   // Current node geometry
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_W:1];
   assign left    = NODE_W'({node_ff, 1'b0} + 1);
   assign right   = NODE_W'({node_ff, 1'b0} + 2);
   assign outside = (hi_ff < qs_ff) || (lo_ff > qe_ff);
   assign covered = (qs_ff <= lo_ff) && (hi_ff <= qe_ff);
   assign top_idx = SI_W'(sp_ff - SP_W'(1));
   assign rd_fl   = rd_ff[HEIGHT_BITS-1:0];
   assign rd_ce   = rd_ff[TAG_W-1:HEIGHT_BITS];
   assign par_fl  = par_ff[HEIGHT_BITS-1:0];
   assign par_ce  = par_ff[TAG_W-1:HEIGHT_BITS];
   assign floor_ext = 32'(rd_fl);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      len_in   = len_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      node_in  = node_ff;
      qs_in    = qs_ff;
      qe_in    = qe_ff;
      fl_in    = fl_ff;
      ce_in    = ce_ff;
      rd_op_in = rd_op_ff;
      par_in   = par_ff;
      hgt_in   = hgt_ff;
      res_in   = res_ff;
      rvld_in  = rvld_ff && !rsp_tready;
      sp_in    = sp_ff;
      push     = 1'b0;
      we       = 1'b0;
      wa       = node_ff;
      wd       = {H_ONES, {HEIGHT_BITS{1'b0}}};
      ra       = node_ff;
      if (csr_valid) len_in = csr_data;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            wa = clr_ff;
            clr_in = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            lo_in   = '0;
            hi_in   = IDX_W'(last_w);
            node_in = '0;
            sp_in   = '0;
            qs_in   = IDX_W'(qs_w);
            if (req_tvalid) begin
               if (req_tuser == OP_READ) begin
                  rd_op_in = 1'b1;
                  qe_in    = IDX_W'(qs_w);
                  if (qs_w > last_w) begin
                     hgt_in   = '0;
                     state_in = S_POP;
                  end else begin
                     state_in = S_VISIT;
                  end
               end else if ((req_tuser == OP_RAISE || req_tuser == OP_LOWER)
                            && qs_w <= qe_w) begin
                  rd_op_in = 1'b0;
                  qe_in    = IDX_W'(qe_w);
                  fl_in    = (req_tuser == OP_RAISE) ? v_sat : '0;
                  ce_in    = (req_tuser == OP_RAISE) ? H_ONES : v_sat;
                  state_in = S_VISIT;
               end
            end
         end
         S_VISIT: begin
            ra = node_ff;
            if (outside) state_in = S_POP;
            else if (covered) state_in = S_LEAF;
            else state_in = S_PD1;
         end
         S_LEAF: begin
            // capture the height on a read, fold the clamp in on an update
            if (rd_op_ff) begin
               hgt_in = floor_ext[VALUE_W-1:0];
            end else begin
               we = 1'b1;
               wa = node_ff;
               wd = compose(rd_ff, fl_ff, ce_ff);
            end
            state_in = S_POP;
         end
         S_PD1: begin
            par_in   = rd_ff;
            ra       = left;
            state_in = S_PD2;
         end
         S_PD2: begin
            we = 1'b1;
            wa = left;
            wd = compose(rd_ff, par_fl, par_ce);
            ra = right;
            state_in = S_PD3;
         end
         S_PD3: begin
            // write the right child, clear the parent on the next cycle
            we = 1'b1;
            wa = right;
            wd = compose(rd_ff, par_fl, par_ce);
            par_in = {H_ONES, {HEIGHT_BITS{1'b0}}};
            push = 1'b1;
            sp_in = sp_ff + SP_W'(1);
            hi_in = mid;
            node_in = left;
            state_in = S_VISIT;
         end
         S_POP: begin
            if (sp_ff != '0) begin
               lo_in    = stk_lo_ff[top_idx];
               hi_in    = stk_hi_ff[top_idx];
               node_in  = stk_node_ff[top_idx];
               sp_in    = sp_ff - SP_W'(1);
               state_in = S_VISIT;
            end else if (!rd_op_ff) begin
               state_in = S_IDLE;
            end else if (!rvld_ff || rsp_tready) begin
               // hand the height to the output word once it is free
               res_in   = hgt_ff;
               rvld_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Parent clear is written in the cycle after the right child; it never
   // collides because the next visit reads the left child.
   logic               pclr_ff, pclr_in;
   logic [NODE_W-1:0]  pnode_ff, pnode_in;
   logic               we_eff;
   logic [NODE_W-1:0]  wa_eff;
   logic [TAG_W-1:0]   wd_eff;

   assign pclr_in  = (state_ff == S_PD3);
   assign pnode_in = node_ff;
   always_comb begin
      we_eff = we;
      wa_eff = wa;
      wd_eff = wd;
      if (pclr_ff) begin
         we_eff = 1'b1;
         wa_eff = pnode_ff;
         wd_eff = {H_ONES, {HEIGHT_BITS{1'b0}}};
      end
   end

   // Tag memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we_eff) mem[wa_eff] <= wd_eff;
      rd_ff <= mem[ra];
   end

   // Frame stack for the right halves still to visit
   always_ff @(posedge clock) begin
      if (push) begin
         stk_lo_ff[sp_ff[SI_W-1:0]]   <= mid + IDX_W'(1);
         stk_hi_ff[sp_ff[SI_W-1:0]]   <= hi_ff;
         stk_node_ff[sp_ff[SI_W-1:0]] <= right;
      end
   end

   // Control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         len_ff   <= LEN_RESET;
         rvld_ff  <= 1'b0;
         sp_ff    <= '0;
         pclr_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         len_ff   <= len_in;
         rvld_ff  <= rvld_in;
         sp_ff    <= sp_in;
         pclr_ff  <= pclr_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      node_ff  <= node_in;
      qs_ff    <= qs_in;
      qe_ff    <= qe_in;
      fl_ff    <= fl_in;
      ce_ff    <= ce_in;
      rd_op_ff <= rd_op_in;
      par_ff   <= par_in;
      hgt_ff   <= hgt_in;
      res_ff   <= res_in;
      pnode_ff <= pnode_in;
   end

   // Stack never overflows
   a_stack_depth: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STK_D))
      else $error("frame stack overflow");

   // No result appears while the tag memory is being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rvld_ff)
      else $error("result during clear");

   // Parent clear always follows the right child write
   a_parent_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PD3 |=> pclr_ff && state_ff == S_VISIT)
      else $error("push-down sequence broken");

endmodule

`default_nettype wire
